[src/rsi_pkg.sv]
// Shared types, constants and helper functions for the ray-sphere intersection block.
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;

   localparam int FRAC_W  = 16;
   localparam int COORD_W = 32;
   localparam int DIR_W   = 18;
   localparam int RAD_W   = 31;
   localparam int SAT_W   = 40;
   localparam int AMAG_W  = 31;
   localparam int LEN_W   = 32;
   localparam int QUO_W   = 17;
   localparam int LANES   = 3;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 152;
   localparam int SQRT_W  = 64;

   localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1 << FRAC_W);

   localparam logic [1:0] REG_CENTRE_X = 2'd0;
   localparam logic [1:0] REG_CENTRE_Y = 2'd1;
   localparam logic [1:0] REG_CENTRE_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   typedef struct packed {
      logic                           hit;
      logic [COORD_W-1:0]             ldotc;
      logic [LANES-1:0][COORD_W-1:0]  org;
      logic [LANES-1:0][DIR_W-1:0]    dir;
   } ray_side_type;

   typedef struct packed {
      logic                           hit;
      logic [LANES-1:0][COORD_W-1:0]  pt;
      logic [LANES-1:0][AMAG_W-1:0]   amag;
      logic [LANES-1:0]               neg;
   } surf_side_type;

   typedef struct packed {
      logic                           hit;
      logic                           len_zero;
      logic [LANES-1:0][COORD_W-1:0]  pt;
      logic [LANES-1:0]               neg;
   } norm_side_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(64'sh7FFF_FFFF);
      lo = -SAT_W'(64'sh8000_0000);
      if (x > hi) begin
         return COORD_W'(hi);
      end else if (x < lo) begin
         return COORD_W'(lo);
      end
      return COORD_W'(x);
   endfunction

   function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] x);
      if (x[COORD_W-1]) begin
         return COORD_W'(-x);
      end
      return COORD_W'(x);
   endfunction

endpackage
`default_nettype wire

[src/rsi_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband that travels along.
`timescale 1ns / 1ps
`default_nettype none
module rsi_isqrt #(
   parameter int IN_W   = 64,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [IN_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [IN_W/2-1:0]      out_root,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int N = IN_W / 2;

   logic              valid_ff [N];
   logic [IN_W-1:0]   x_ff     [N];
   logic [N:0]        rem_ff   [N];
   logic [N-1:0]      root_ff  [N];
   logic [SIDE_W-1:0] side_ff  [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic              p_valid;
      logic [IN_W-1:0]   p_x;
      logic [N:0]        p_rem;
      logic [N-1:0]      p_root;
      logic [SIDE_W-1:0] p_side;
      logic [N+2:0]      t;
      logic [N+2:0]      trial;
      logic              ge;

      if (i == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_x     = in_rad;
         assign p_rem   = '0;
         assign p_root  = '0;
         assign p_side  = in_side;
      end else begin : g_next
         assign p_valid = valid_ff[i-1];
         assign p_x     = x_ff[i-1];
         assign p_rem   = rem_ff[i-1];
         assign p_root  = root_ff[i-1];
         assign p_side  = side_ff[i-1];
      end

      assign t     = {p_rem, p_x[IN_W-1 -: 2]};
      assign trial = {1'b0, p_root, 2'b01};
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= p_valid;
         end
         if (en) begin
            x_ff[i]    <= {p_x[IN_W-3:0], 2'b00};
            rem_ff[i]  <= ge ? (N+1)'(t - trial) : t[N:0];
            root_ff[i] <= {p_root[N-2:0], ge};
            side_ff[i] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule
`default_nettype wire

[src/rsi_ndiv.sv]
// Pipelined restoring divider for the three normal lanes, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rsi_ndiv #(
   parameter int SIDE_W = 1
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         en,
   input  wire logic                                         in_valid,
   input  wire logic [rsi_pkg::LANES-1:0][rsi_pkg::AMAG_W-1:0] in_num,
   input  wire logic [rsi_pkg::LEN_W-1:0]                    in_den,
   input  wire logic [SIDE_W-1:0]                            in_side,
   output logic                                              out_valid,
   output logic [rsi_pkg::LANES-1:0][rsi_pkg::QUO_W-1:0]     out_quo,
   output logic [SIDE_W-1:0]                                 out_side
);
   localparam int L  = rsi_pkg::LANES;
   localparam int Q  = rsi_pkg::QUO_W;
   localparam int D  = rsi_pkg::LEN_W;
   localparam int NW = rsi_pkg::AMAG_W;
   localparam int F  = rsi_pkg::FRAC_W;

   logic              valid_ff [Q];
   logic [D-1:0]      den_ff   [Q];
   logic [SIDE_W-1:0] side_ff  [Q];
   logic [D-1:0]      rem_ff   [Q][L];
   logic [Q-1:0]      tail_ff  [Q][L];
   logic [Q-1:0]      quo_ff   [Q][L];

   for (genvar i = 0; i < Q; i++) begin : g_step
      logic              p_valid;
      logic [D-1:0]      p_den;
      logic [SIDE_W-1:0] p_side;

      if (i == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_den   = in_den;
         assign p_side  = in_side;
      end else begin : g_next
         assign p_valid = valid_ff[i-1];
         assign p_den   = den_ff[i-1];
         assign p_side  = side_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= p_valid;
         end
         if (en) begin
            den_ff[i]  <= p_den;
            side_ff[i] <= p_side;
         end
      end

      for (genvar k = 0; k < L; k++) begin : g_lane
         logic [D-1:0] p_rem;
         logic [Q-1:0] p_tail;
         logic [Q-1:0] p_quo;
         logic [D:0]   t;
         logic         ge;

         if (i == 0) begin : g_first
            assign p_rem  = D'(in_num[k] >> (Q - F));
            assign p_tail = Q'({in_num[k], F'(0)});
            assign p_quo  = '0;
         end else begin : g_next
            assign p_rem  = rem_ff[i-1][k];
            assign p_tail = tail_ff[i-1][k];
            assign p_quo  = quo_ff[i-1][k];
         end

         assign t  = {p_rem, p_tail[Q-1]};
         assign ge = (t >= {1'b0, p_den});

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i][k]  <= ge ? D'(t - {1'b0, p_den}) : t[D-1:0];
               tail_ff[i][k] <= {p_tail[Q-2:0], 1'b0};
               quo_ff[i][k]  <= {p_quo[Q-2:0], ge};
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < L; k++) begin
         out_quo[k] = quo_ff[Q-1][k];
      end
   end

   assign out_valid = valid_ff[Q-1];
   assign out_side  = side_ff[Q-1];
endmodule
`default_nettype wire

[src/rsi_outq.sv]
// Output register with a one-entry skid buffer that decouples the result side from the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module rsi_outq #(
   parameter int DATA_W = 8,
   parameter int USER_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [DATA_W-1:0] in_data,
   input  wire logic [USER_W-1:0] in_user,
   output logic                   advance,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [DATA_W-1:0]      out_data,
   output logic [USER_W-1:0]      out_user
);
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic [USER_W-1:0] out_user_ff;
   logic              skid_valid_ff;
   logic [DATA_W-1:0] skid_data_ff;
   logic [USER_W-1:0] skid_user_ff;

   assign advance = ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_ready) begin
         out_valid_ff <= in_valid;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_ff <= skid_data_ff;
            out_user_ff <= skid_user_ff;
         end
      end else if (!out_valid_ff || out_ready) begin
         out_data_ff <= in_data;
         out_user_ff <= in_user;
      end else begin
         skid_data_ff <= in_data;
         skid_user_ff <= in_user;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_user  = out_user_ff;
endmodule
`default_nettype wire

[src/ray_sphere_intersect_top.sv]
// Top level of the ray-sphere intersection pipeline with its register port.
//
//   Channel  Direction  Contents
//   req_     in         tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
//   rsp_     out        tdata: point_x/y/z, normal_x/y/z; tuser: hit
//   csr_     in/out     centre_x, centre_y, centre_z, sphere_radius at 0x0, 0x4, 0x8, 0xC
//
// One request is taken per cycle while the pipeline is not stalled.
// The pipeline holds two 32-stage square root pipelines and a 17-stage divider.
// Reset clears all valid bits and loads a unit radius with the centre at the origin.
// The pipeline stalls as a whole only while the skid entry behind the output register is full.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_intersect_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [rsi_pkg::DATA_W-1:0]  req_tdata,   // origin_x/y/z, dir_x/y/z
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [rsi_pkg::DATA_W-1:0]       rsp_tdata,   // point_x/y/z, normal_x/y/z
   output logic                             rsp_tuser,   // hit
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rsi_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   localparam int L  = rsi_pkg::LANES;
   localparam int CW = rsi_pkg::COORD_W;
   localparam int DW = rsi_pkg::DIR_W;
   localparam int SW = rsi_pkg::SAT_W;
   localparam int AW = rsi_pkg::AMAG_W;
   localparam int F  = rsi_pkg::FRAC_W;
   localparam int SQRT_W = rsi_pkg::SQRT_W;
   localparam int RW = SQRT_W / 2;

   logic en;

   logic signed [CW-1:0]       centre_ff [L];
   logic [rsi_pkg::RAD_W-1:0]  radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) begin
            centre_ff[i] <= '0;
         end
         radius_ff <= rsi_pkg::RAD_W'(1 << F);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            rsi_pkg::REG_CENTRE_X: centre_ff[0] <= csr_pwdata;
            rsi_pkg::REG_CENTRE_Y: centre_ff[1] <= csr_pwdata;
            rsi_pkg::REG_CENTRE_Z: centre_ff[2] <= csr_pwdata;
            rsi_pkg::REG_RADIUS:   radius_ff    <= csr_pwdata[rsi_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         rsi_pkg::REG_CENTRE_X: csr_prdata = centre_ff[0];
         rsi_pkg::REG_CENTRE_Y: csr_prdata = centre_ff[1];
         rsi_pkg::REG_CENTRE_Z: csr_prdata = centre_ff[2];
         rsi_pkg::REG_RADIUS:   csr_prdata = {1'b0, radius_ff};
         default:               csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = en;

   // Stage 1: shifted centre.
   logic                 v1_ff;
   logic signed [CW-1:0] org_in [L];
   logic signed [DW-1:0] dir_in [L];
   logic signed [CW-1:0] c1_in  [L];
   logic signed [CW-1:0] org1_ff [L];
   logic signed [DW-1:0] dir1_ff [L];
   logic signed [CW-1:0] c1_ff   [L];

   always_comb begin
      for (int i = 0; i < L; i++) begin
         org_in[i] = req_tdata[CW*i +: CW];
         dir_in[i] = req_tdata[CW*L + DW*i +: DW];
         c1_in[i]  = rsi_pkg::sat32(SW'(centre_ff[i]) - SW'(org_in[i]));
      end
   end

   // Stage 2: direction products and squared centre terms.
   logic                      v2_ff;
   logic signed [49:0]        pr2_in  [L];
   logic [63:0]               sq2_in  [L];
   logic signed [49:0]        pr2_ff  [L];
   logic [63:0]               sq2_ff  [L];
   logic signed [CW-1:0]      org2_ff [L];
   logic signed [DW-1:0]      dir2_ff [L];

   always_comb begin
      for (int i = 0; i < L; i++) begin
         pr2_in[i] = 50'(dir1_ff[i]) * 50'(c1_ff[i]);
         sq2_in[i] = rsi_pkg::mag32(c1_ff[i]) * rsi_pkg::mag32(c1_ff[i]);
      end
   end

   // Stage 3: dot product and squared length of the shifted centre.
   logic                 v3_ff;
   logic signed [51:0]   acc3;
   logic signed [51:0]   acc3_sh;
   logic signed [CW-1:0] ld3_in;
   logic [63:0]          neg3_in;
   logic signed [CW-1:0] ld3_ff;
   logic [63:0]          neg3_ff;
   logic signed [CW-1:0] org3_ff [L];
   logic signed [DW-1:0] dir3_ff [L];

   always_comb begin
      acc3    = 52'(pr2_ff[0]) + 52'(pr2_ff[1]) + 52'(pr2_ff[2]);
      acc3_sh = acc3 >>> F;
      ld3_in  = rsi_pkg::sat32(SW'(acc3_sh));
      neg3_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
   end

   // Stage 4: squares of the dot product and of the radius.
   logic                 v4_ff;
   logic [63:0]          lsq4_in;
   logic [61:0]          rsq4_in;
   logic [63:0]          lsq4_ff;
   logic [61:0]          rsq4_ff;
   logic [63:0]          neg4_ff;
   logic signed [CW-1:0] ld4_ff;
   logic signed [CW-1:0] org4_ff [L];
   logic signed [DW-1:0] dir4_ff [L];

   always_comb begin
      lsq4_in = rsi_pkg::mag32(ld3_ff) * rsi_pkg::mag32(ld3_ff);
      rsq4_in = radius_ff * radius_ff;
   end

   // Stage 5: discriminant and hit decision.
   logic                      v5_ff;
   logic [63:0]               pos5;
   logic [SQRT_W-1:0]         disc5_ff;
   rsi_pkg::ray_side_type     ray5_in;
   rsi_pkg::ray_side_type     ray5_ff;

   always_comb begin
      pos5          = lsq4_ff + 64'(rsq4_ff);
      ray5_in.hit   = (pos5 >= neg4_ff);
      ray5_in.ldotc = ld4_ff;
      for (int i = 0; i < L; i++) begin
         ray5_in.org[i] = org4_ff[i];
         ray5_in.dir[i] = dir4_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            org1_ff[i] <= org_in[i];
            dir1_ff[i] <= dir_in[i];
            c1_ff[i]   <= c1_in[i];
            pr2_ff[i]  <= pr2_in[i];
            sq2_ff[i]  <= sq2_in[i];
            org2_ff[i] <= org1_ff[i];
            dir2_ff[i] <= dir1_ff[i];
            org3_ff[i] <= org2_ff[i];
            dir3_ff[i] <= dir2_ff[i];
            org4_ff[i] <= org3_ff[i];
            dir4_ff[i] <= dir3_ff[i];
         end
         ld3_ff   <= ld3_in;
         neg3_ff  <= neg3_in;
         lsq4_ff  <= lsq4_in;
         rsq4_ff  <= rsq4_in;
         neg4_ff  <= neg3_ff;
         ld4_ff   <= ld3_ff;
         disc5_ff <= SQRT_W'(pos5 - neg4_ff);
         ray5_ff  <= ray5_in;
      end
   end

   // Square root of the discriminant.
   logic                   sq1_valid;
   logic [RW-1:0]          sq1_root;
   rsi_pkg::ray_side_type  sq1_side;

   rsi_isqrt #(
      .IN_W   (SQRT_W),
      .SIDE_W ($bits(rsi_pkg::ray_side_type))
   ) u_disc_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_rad    (disc5_ff),
      .in_side   (ray5_ff),
      .out_valid (sq1_valid),
      .out_root  (sq1_root),
      .out_side  (sq1_side)
   );

   // Stage 6: distance.
   logic                  v6_ff;
   logic signed [33:0]    dist6_ff;
   rsi_pkg::ray_side_type ray6_ff;

   // Stage 7: direction times distance.
   logic                  v7_ff;
   logic signed [51:0]    pr7_in [L];
   logic signed [51:0]    pr7_ff [L];
   rsi_pkg::ray_side_type ray7_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         pr7_in[i] = 52'($signed(ray6_ff.dir[i])) * 52'(dist6_ff);
      end
   end

   // Stage 8: intersection point.
   logic                  v8_ff;
   logic signed [51:0]    pr8_sh [L];
   logic signed [CW-1:0]  pt8_in [L];
   logic signed [CW-1:0]  pt8_ff [L];
   logic                  hit8_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         pr8_sh[i] = pr7_ff[i] >>> F;
         pt8_in[i] = rsi_pkg::sat32(SW'($signed(ray7_ff.org[i])) + SW'(pr8_sh[i]));
      end
   end

   // Stage 9: point relative to the centre, split into sign and magnitude.
   logic                  v9_ff;
   logic signed [CW:0]    rel9   [L];
   logic [CW:0]           amag9_in [L];
   logic [CW:0]           amag9_ff [L];
   logic [L-1:0]          neg9_ff;
   logic signed [CW-1:0]  pt9_ff [L];
   logic                  hit9_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         rel9[i]     = (CW+1)'(pt8_ff[i]) - (CW+1)'(centre_ff[i]);
         amag9_in[i] = rel9[i][CW] ? (CW+1)'(-rel9[i]) : (CW+1)'(rel9[i]);
      end
   end

   // Stage 10: range reduction so the squares fit.
   logic                  v10_ff;
   logic                  big10;
   logic [AW-1:0]         a10_in [L];
   logic [AW-1:0]         a10_ff [L];
   logic [L-1:0]          neg10_ff;
   logic signed [CW-1:0]  pt10_ff [L];
   logic                  hit10_ff;

   always_comb begin
      big10 = 1'b0;
      for (int i = 0; i < L; i++) begin
         big10 = big10 | (|amag9_ff[i][CW:AW]);
      end
      for (int i = 0; i < L; i++) begin
         a10_in[i] = big10 ? AW'(amag9_ff[i] >> 2) : amag9_ff[i][AW-1:0];
      end
   end

   // Stage 11: squares; stage 12: their sum.
   logic                  v11_ff;
   logic [2*AW-1:0]       sq11_ff [L];
   rsi_pkg::surf_side_type surf11_ff;
   rsi_pkg::surf_side_type surf10;

   always_comb begin
      surf10.hit = hit10_ff;
      for (int i = 0; i < L; i++) begin
         surf10.pt[i]   = pt10_ff[i];
         surf10.amag[i] = a10_ff[i];
         surf10.neg[i]  = neg10_ff[i];
      end
   end

   logic                   v12_ff;
   logic [SQRT_W-1:0]      sum12_ff;
   rsi_pkg::surf_side_type surf12_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
      end else if (en) begin
         v6_ff  <= sq1_valid;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist6_ff <= 34'($signed(sq1_side.ldotc)) - 34'(sq1_root);
         ray6_ff  <= sq1_side;
         ray7_ff  <= ray6_ff;
         hit8_ff  <= ray7_ff.hit;
         hit9_ff  <= hit8_ff;
         hit10_ff <= hit9_ff;
         for (int i = 0; i < L; i++) begin
            pr7_ff[i]   <= pr7_in[i];
            pt8_ff[i]   <= pt8_in[i];
            amag9_ff[i] <= amag9_in[i];
            neg9_ff[i]  <= rel9[i][CW];
            pt9_ff[i]   <= pt8_ff[i];
            a10_ff[i]   <= a10_in[i];
            neg10_ff[i] <= neg9_ff[i];
            pt10_ff[i]  <= pt9_ff[i];
            sq11_ff[i]  <= a10_ff[i] * a10_ff[i];
         end
         surf11_ff <= surf10;
         sum12_ff  <= SQRT_W'(sq11_ff[0]) + SQRT_W'(sq11_ff[1]) + SQRT_W'(sq11_ff[2]);
         surf12_ff <= surf11_ff;
      end
   end

   // Length of the unnormalized normal.
   logic                   sq2_valid;
   logic [RW-1:0]          sq2_root;
   rsi_pkg::surf_side_type sq2_side;

   rsi_isqrt #(
      .IN_W   (SQRT_W),
      .SIDE_W ($bits(rsi_pkg::surf_side_type))
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v12_ff),
      .in_rad    (sum12_ff),
      .in_side   (surf12_ff),
      .out_valid (sq2_valid),
      .out_root  (sq2_root),
      .out_side  (sq2_side)
   );

   rsi_pkg::norm_side_type div_side_in;
   always_comb begin
      div_side_in.hit      = sq2_side.hit;
      div_side_in.len_zero = (sq2_root == '0);
      div_side_in.pt       = sq2_side.pt;
      div_side_in.neg      = sq2_side.neg;
   end

   logic                                         dv_valid;
   logic [L-1:0][rsi_pkg::QUO_W-1:0]             dv_quo;
   rsi_pkg::norm_side_type                       dv_side;

   rsi_ndiv #(
      .SIDE_W ($bits(rsi_pkg::norm_side_type))
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq2_valid),
      .in_num    (sq2_side.amag),
      .in_den    (rsi_pkg::LEN_W'(sq2_root)),
      .in_side   (div_side_in),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Result assembly.
   logic [rsi_pkg::QUO_W-1:0] q_clip [L];
   logic [DW-1:0]             nrm    [L];
   logic [CW-1:0]             pto    [L];
   logic [rsi_pkg::DATA_W-1:0] out_data;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         q_clip[i] = (dv_quo[i] > rsi_pkg::ONE_Q) ? rsi_pkg::ONE_Q : dv_quo[i];
         if (!dv_side.hit || dv_side.len_zero) begin
            nrm[i] = '0;
         end else if (dv_side.neg[i]) begin
            nrm[i] = DW'(-(DW'(q_clip[i])));
         end else begin
            nrm[i] = DW'(q_clip[i]);
         end
         pto[i] = dv_side.hit ? dv_side.pt[i] : '0;
      end
      out_data = {2'b00, nrm[2], nrm[1], nrm[0], pto[2], pto[1], pto[0]};
   end

   rsi_outq #(
      .DATA_W (rsi_pkg::DATA_W),
      .USER_W (1)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_data   (out_data),
      .in_user   (dv_side.hit),
      .advance   (en),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser)
   );
endmodule
`default_nettype wire

[src/rsi_checker.sv]
// Port-level checks for the ray-sphere intersection top level, bound to every instance.
`timescale 1ns / 1ps
`default_nettype none
module rsi_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [rsi_pkg::DATA_W-1:0] rsp_tdata,
   input wire logic                       rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss carries nonzero point or normal");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && $past(rsp_tvalid))
      else $error("request side stalled without a pending result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[113:96])  <= 18'sd65536 && $signed(rsp_tdata[113:96])  >= -18'sd65536 &&
         $signed(rsp_tdata[131:114]) <= 18'sd65536 && $signed(rsp_tdata[131:114]) >= -18'sd65536 &&
         $signed(rsp_tdata[149:132]) <= 18'sd65536 && $signed(rsp_tdata[149:132]) >= -18'sd65536)
      else $error("normal component out of range");
endmodule

bind ray_sphere_intersect_top rsi_checker u_rsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
